### rtl/ftq_pkg.sv
// Shared types, codes and constants for the timer queue.
`timescale 1ns / 1ps

package ftq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int DL_W = 64;
	localparam int ID_W = 32;
	localparam int PROD_W = 62;

	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

	localparam logic [2:0] CMD_SET = 3'd0;
	localparam logic [2:0] CMD_CHECK = 3'd1;
	localparam logic [2:0] CMD_CANCEL = 3'd2;
	localparam logic [2:0] CMD_UPTO = 3'd3;
	localparam logic [2:0] CMD_QUERY = 3'd4;

	localparam logic [1:0] STATUS_DONE = 2'd0;
	localparam logic [1:0] STATUS_NONE = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_MUL,
		FSM_ADD_NOW,
		FSM_ADD_NSEC,
		FSM_SCAN,
		FSM_RESP
	} fsm_t;

	// write strobes of one cell
	typedef struct packed {
		logic wr_new;
		logic wr_next;
	} cell_wr_t;

	// id match request shared by all cells
	typedef struct packed {
		logic upto;
		logic [ID_W-1:0] target;
	} cell_match_t;

endpackage

### rtl/ftq_cell.sv
// One timer slot: holds a deadline and id, loads a new entry or its neighbor's, flags an id match.
`timescale 1ns / 1ps

module ftq_cell (
	input  logic                          clk,
	input  ftq_pkg::cell_wr_t             wr,
	input  ftq_pkg::cell_match_t          match,
	input  logic [ftq_pkg::DL_W-1:0]      new_dl,
	input  logic [ftq_pkg::ID_W-1:0]      new_id,
	input  logic [ftq_pkg::DL_W-1:0]      next_dl,
	input  logic [ftq_pkg::ID_W-1:0]      next_id,
	output logic [ftq_pkg::DL_W-1:0]      dl,
	output logic [ftq_pkg::ID_W-1:0]      id,
	output logic                          hit
);

	logic [ftq_pkg::DL_W-1:0] dl_q;
	logic [ftq_pkg::ID_W-1:0] id_q;

	always_ff @(posedge clk) begin
		if (wr.wr_new) begin
			dl_q <= new_dl;
			id_q <= new_id;
		end else if (wr.wr_next) begin
			dl_q <= next_dl;
			id_q <= next_id;
		end
	end

	assign dl = dl_q;
	assign id = id_q;
	assign hit = match.upto ? (id_q <= match.target) : (id_q == match.target);

endmodule

### rtl/fifo_timer_queue.sv
// Top level of the timer queue: command FSM, deadline arithmetic and the cell row.
`timescale 1ns / 1ps

// Timer queue kept in insertion order in a row of QUEUE_DEPTH slots.
// Slave channel: one request per beat; s_tuser carries the command code,
// s_tdata carries now, delay seconds, delay nanoseconds and target id.
// Master channel: one response per request, all fields in m_tdata.
// Requests are handled one at a time; s_tready is high only while idle.
// Steps from accept to response valid:
//   set                       multiply, two saturating adds, respond
//   set on a full queue       respond
//   check, query, other codes respond
//   cancel, cancel-until      walk slots (1 to occupancy of them), respond;
//                             respond only on an empty queue
// The cancel walk tests one slot per cycle; the set path is bounded by the
// 32x30 multiplier and the 64-bit saturating adders.
// A removal shifts every slot behind the removed one forward by one, all
// at the same clock edge, each slot taking its neighbor's contents.
// Reset empties the queue and restarts ids at 1; slot contents are not cleared.
// When m_tready is low the response holds in its output register; a new
// request may still be taken, and its response waits until the register frees.
module fifo_timer_queue #(
	parameter int QUEUE_DEPTH = ftq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [2:0]   s_tuser,   // command
	input  logic [159:0] s_tdata,   // now_ns[63:0], delay_sec, delay_nsec, target_id
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata    // status, result_id, fired, remaining_ns, occupancy
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int DL_W = ftq_pkg::DL_W;
	localparam int ID_W = ftq_pkg::ID_W;

	ftq_pkg::fsm_t state_q, state_d;

	// request registers
	logic [2:0]      cmd_q;
	logic [63:0]     now_q;
	logic [31:0]     sec_q;
	logic [31:0]     nsec_q;
	logic [31:0]     target_q;

	// queue control
	logic [CNT_W-1:0] count_q;
	logic [ID_W-1:0]  next_id_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] pos_q;
	logic             found_q;
	logic [ID_W-1:0]  found_id_q;

	// deadline arithmetic
	logic [ftq_pkg::PROD_W-1:0] prod_s1;
	logic [DL_W-1:0]            dl_q;
	logic [DL_W:0]              sum_now;
	logic [DL_W:0]              sum_nsec;

	// output register
	logic         m_tvalid_q;
	logic [103:0] m_tdata_q;

	// cell row
	logic [DL_W-1:0]     cell_dl [QUEUE_DEPTH];
	logic [ID_W-1:0]     cell_id [QUEUE_DEPTH];
	logic [DL_W-1:0]     nbr_dl  [QUEUE_DEPTH];
	logic [ID_W-1:0]     nbr_id  [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_hit;
	ftq_pkg::cell_wr_t   cell_wr [QUEUE_DEPTH];
	ftq_pkg::cell_match_t match;

	// response decode
	logic            accept;
	logic            out_free;
	logic            commit;
	logic            do_append;
	logic            do_remove;
	logic [1:0]      r_status;
	logic [ID_W-1:0] r_id;
	logic            r_fired;
	logic [63:0]     r_remaining;
	logic [CNT_W-1:0] count_d;
	logic            is_full;
	logic            is_empty;
	logic            scan_hit;
	logic            scan_last;

	assign accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign is_full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);
	assign scan_hit = cell_hit[idx_q];
	assign scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) >= count_q);

	assign sum_now = {1'b0, now_q} + {{(DL_W + 1 - ftq_pkg::PROD_W){1'b0}}, prod_s1};
	assign sum_nsec = {1'b0, dl_q} + {33'b0, nsec_q};

	assign match.upto = (cmd_q == ftq_pkg::CMD_UPTO);
	assign match.target = target_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ftq_pkg::FSM_IDLE: begin
				if (s_tvalid) begin
					priority if (s_tuser == ftq_pkg::CMD_SET && !is_full)
						state_d = ftq_pkg::FSM_MUL;
					else if ((s_tuser == ftq_pkg::CMD_CANCEL || s_tuser == ftq_pkg::CMD_UPTO)
						&& !is_empty)
						state_d = ftq_pkg::FSM_SCAN;
					else
						state_d = ftq_pkg::FSM_RESP;
				end
			end
			ftq_pkg::FSM_MUL:      state_d = ftq_pkg::FSM_ADD_NOW;
			ftq_pkg::FSM_ADD_NOW:  state_d = ftq_pkg::FSM_ADD_NSEC;
			ftq_pkg::FSM_ADD_NSEC: state_d = ftq_pkg::FSM_RESP;
			ftq_pkg::FSM_SCAN: begin
				if (scan_hit || scan_last)
					state_d = ftq_pkg::FSM_RESP;
			end
			ftq_pkg::FSM_RESP: begin
				if (out_free)
					state_d = ftq_pkg::FSM_IDLE;
			end
			default: state_d = ftq_pkg::FSM_IDLE;
		endcase
	end

	// outputs and response decode
	always_comb begin
		s_tready = (state_q == ftq_pkg::FSM_IDLE);
		commit = (state_q == ftq_pkg::FSM_RESP) && out_free;
		do_append = 1'b0;
		do_remove = 1'b0;
		r_status = ftq_pkg::STATUS_NONE;
		r_id = '0;
		r_fired = 1'b0;
		r_remaining = '0;
		unique case (cmd_q)
			ftq_pkg::CMD_SET: begin
				if (is_full) begin
					r_status = ftq_pkg::STATUS_FULL;
				end else begin
					do_append = 1'b1;
					r_status = ftq_pkg::STATUS_DONE;
					r_id = next_id_q;
				end
			end
			ftq_pkg::CMD_CHECK: begin
				if (!is_empty && cell_dl[0] <= now_q) begin
					do_remove = 1'b1;
					r_status = ftq_pkg::STATUS_DONE;
					r_id = cell_id[0];
					r_fired = 1'b1;
				end
			end
			ftq_pkg::CMD_CANCEL, ftq_pkg::CMD_UPTO: begin
				if (found_q) begin
					do_remove = 1'b1;
					r_status = ftq_pkg::STATUS_DONE;
					r_id = found_id_q;
				end
			end
			ftq_pkg::CMD_QUERY: begin
				if (!is_empty) begin
					r_status = ftq_pkg::STATUS_DONE;
					if (cell_dl[0] > now_q)
						r_remaining = cell_dl[0] - now_q;
				end
			end
			default: begin
			end
		endcase
		count_d = count_q;
		if (commit && do_append)
			count_d = count_q + CNT_W'(1);
		else if (commit && do_remove)
			count_d = count_q - CNT_W'(1);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ftq_pkg::FSM_IDLE;
			count_q <= '0;
			next_id_q <= ID_W'(1);
			m_tvalid_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (commit && do_append)
				next_id_q <= next_id_q + ID_W'(1);
			if (accept)
				found_q <= 1'b0;
			else if (state_q == ftq_pkg::FSM_SCAN && scan_hit)
				found_q <= 1'b1;
			if (commit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ftq_pkg::FSM_IDLE: begin
				if (accept) begin
					cmd_q <= s_tuser;
					now_q <= s_tdata[63:0];
					sec_q <= s_tdata[95:64];
					nsec_q <= s_tdata[127:96];
					target_q <= s_tdata[159:128];
					idx_q <= '0;
					pos_q <= '0;
				end
			end
			ftq_pkg::FSM_MUL: begin
				prod_s1 <= ftq_pkg::PROD_W'(sec_q) * ftq_pkg::PROD_W'(ftq_pkg::NS_PER_SEC);
			end
			ftq_pkg::FSM_ADD_NOW: begin
				dl_q <= sum_now[DL_W] ? {DL_W{1'b1}} : sum_now[DL_W-1:0];
			end
			ftq_pkg::FSM_ADD_NSEC: begin
				dl_q <= sum_nsec[DL_W] ? {DL_W{1'b1}} : sum_nsec[DL_W-1:0];
			end
			ftq_pkg::FSM_SCAN: begin
				// hold the walk position once a slot matches
				pos_q <= idx_q;
				found_id_q <= cell_id[idx_q];
				if (!scan_hit && !scan_last)
					idx_q <= idx_q + IDX_W'(1);
			end
			ftq_pkg::FSM_RESP: begin
			end
			default: begin
			end
		endcase
		if (commit)
			m_tdata_q <= {5'(count_d), r_remaining, r_fired, r_id, r_status};
	end

	// slot row: append at the fill count, shift forward from the removed slot
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign nbr_dl[i] = '0;
			assign nbr_id[i] = '0;
		end else begin : g_body
			assign nbr_dl[i] = cell_dl[i+1];
			assign nbr_id[i] = cell_id[i+1];
		end

		assign cell_wr[i].wr_new = commit && do_append && (count_q == CNT_W'(i));
		assign cell_wr[i].wr_next = commit && do_remove && (IDX_W'(i) >= pos_q);

		ftq_cell u_cell (
			.clk     (clk),
			.wr      (cell_wr[i]),
			.match   (match),
			.new_dl  (dl_q),
			.new_id  (next_id_q),
			.next_dl (nbr_dl[i]),
			.next_id (nbr_id[i]),
			.dl      (cell_dl[i]),
			.id      (cell_id[i]),
			.hit     (cell_hit[i])
		);
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	// occupancy never exceeds the row
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("timer queue count beyond depth");

	// occupancy only moves when a response is committed
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ftq_pkg::FSM_RESP) |=> $stable(count_q))
		else $error("timer queue count changed outside response");

	// a new response only appears after the response state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ftq_pkg::FSM_RESP))
		else $error("response without request");

	// the walk stays inside the filled slots
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ftq_pkg::FSM_SCAN) |-> (CNT_W'(idx_q) < count_q))
		else $error("cancel walk past the fill count");

endmodule

### sim/fifo_timer_queue_tb.sv
// Self-checking testbench for the timer queue: stream driver, monitor and response predictor.
`timescale 1ns / 1ps

// Requests go in on the slave stream: s_tuser holds the command and s_tdata packs
// {target_id, delay_nsec, delay_sec, now_ns}. Each response comes out on m_tdata.
// A request is predicted when it is accepted. Each response is checked against the
// oldest prediction, one field at a time.
// The sender runs in bursts with random gaps. The receiver stalls in a pattern
// that cycles through four modes.
module fifo_timer_queue_tb;

	localparam int DEPTH = ftq_pkg::QUEUE_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 650;
	// codes with no meaning; the block must answer "nothing to do"
	localparam logic [2:0] CMD_RSVD5 = 3'd5;
	localparam logic [2:0] CMD_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;

	typedef struct {
		logic [2:0]  cmd;
		logic [63:0] now;
		logic [31:0] sec;
		logic [31:0] nsec;
		logic [31:0] target;
	} timer_req_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] rid;
		logic        fired;
		logic [63:0] remaining;
		logic [4:0]  occupancy;
	} timer_rsp_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [2:0]   s_tuser = '0;    // command
	logic [159:0] s_tdata = '0;    // now_ns, delay_sec, delay_nsec, target_id
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;         // status, result_id, fired, remaining_ns, occupancy

	timer_req_t pend_q[$];
	timer_rsp_t rsp_q[$];
	int err_count = 0;
	bit req_taken = 1'b0;

	// predictor state: the pending timers in insertion order
	logic [63:0] q_deadline[DEPTH];
	logic [31:0] q_id[DEPTH];
	int          q_count = 0;
	logic [31:0] q_next_id = 32'd1;

	fifo_timer_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

	// Drop slot pos and close the hole, keeping the order of the rest.
	function automatic void drop_slot(int pos);
		for (int k = pos; k + 1 < q_count; k++) begin
			q_deadline[k] = q_deadline[k + 1];
			q_id[k] = q_id[k + 1];
		end
		q_count--;
	endfunction

	// Apply one request to the predictor state and return the response it must give.
	function automatic timer_rsp_t timer_queue_apply(timer_req_t r);
		timer_rsp_t o;
		logic [63:0] prod;
		bit hit;
		o.status = ftq_pkg::STATUS_NONE;
		o.rid = '0;
		o.fired = 1'b0;
		o.remaining = '0;
		case (r.cmd)
			ftq_pkg::CMD_SET: begin
				if (q_count >= DEPTH) begin
					o.status = ftq_pkg::STATUS_FULL;
				end else begin
					prod = {32'd0, r.sec} * {34'd0, ftq_pkg::NS_PER_SEC};
					q_deadline[q_count] = add_sat(add_sat(r.now, prod), {32'd0, r.nsec});
					q_id[q_count] = q_next_id;
					o.rid = q_next_id;
					q_next_id = q_next_id + 32'd1;
					q_count++;
					o.status = ftq_pkg::STATUS_DONE;
				end
			end
			ftq_pkg::CMD_CHECK: begin
				if (q_count > 0 && q_deadline[0] <= r.now) begin
					o.rid = q_id[0];
					o.fired = 1'b1;
					o.status = ftq_pkg::STATUS_DONE;
					drop_slot(0);
				end
			end
			ftq_pkg::CMD_CANCEL, ftq_pkg::CMD_UPTO: begin
				for (int k = 0; k < q_count; k++) begin
					hit = (r.cmd == ftq_pkg::CMD_CANCEL) ? (q_id[k] == r.target)
						: (q_id[k] <= r.target);
					if (hit) begin
						o.rid = q_id[k];
						o.status = ftq_pkg::STATUS_DONE;
						drop_slot(k);
						break;
					end
				end
			end
			ftq_pkg::CMD_QUERY: begin
				if (q_count > 0) begin
					o.remaining = (q_deadline[0] > r.now) ? q_deadline[0] - r.now : 64'd0;
					o.status = ftq_pkg::STATUS_DONE;
				end
			end
			default: ;
		endcase
		o.occupancy = q_count[4:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
		$display("%0t mismatch %s: expected %0h got %0h", $realtime, what, want, got);
		err_count++;
	endtask

	task automatic add_req(logic [2:0] cmd, logic [63:0] now, logic [31:0] sec,
			logic [31:0] nsec, logic [31:0] target);
		timer_req_t r;
		r.cmd = cmd;
		r.now = now;
		r.sec = sec;
		r.nsec = nsec;
		r.target = target;
		pend_q.push_back(r);
	endtask

	// Sender: offer requests in bursts, hold each one until it is taken.
	int burst_left = 4;
	int gap_left = 0;
	always @(negedge clk) begin
		timer_req_t r;
		if (arst_n && !(s_tvalid && !req_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pend_q.size() > 0) begin
				r = pend_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= r.cmd;
				s_tdata <= {r.target, r.nsec, r.sec, r.now};
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern cycles through four modes.
	int rx_cyc = 0;
	always @(negedge clk) begin
		rx_cyc++;
		case ((rx_cyc / 50) % 4)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= (rx_cyc % 7) < 3;
			default: m_tready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	// Monitor: predict on each accepted request, check each accepted response.
	always @(posedge clk) begin
		timer_req_t r;
		timer_rsp_t want;
		timer_rsp_t got;
		if (!arst_n) begin
			req_taken = 1'b0;
		end else begin
			req_taken = s_tvalid && s_tready;
			if (req_taken) begin
				r.cmd = s_tuser;
				r.now = s_tdata[63:0];
				r.sec = s_tdata[95:64];
				r.nsec = s_tdata[127:96];
				r.target = s_tdata[159:128];
				rsp_q.push_back(timer_queue_apply(r));
			end
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[1:0];
				got.rid = m_tdata[33:2];
				got.fired = m_tdata[34];
				got.remaining = m_tdata[98:35];
				got.occupancy = m_tdata[103:99];
				if (rsp_q.size() == 0) begin
					report_mismatch("response with nothing pending", 64'd0, m_tdata[63:0]);
				end else begin
					want = rsp_q.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", 64'(want.status), 64'(got.status));
					if (got.rid !== want.rid)
						report_mismatch("result_id", 64'(want.rid), 64'(got.rid));
					if (got.fired !== want.fired)
						report_mismatch("fired", 64'(want.fired), 64'(got.fired));
					if (got.remaining !== want.remaining)
						report_mismatch("remaining_ns", want.remaining, got.remaining);
					if (got.occupancy !== want.occupancy)
						report_mismatch("occupancy", 64'(want.occupancy), 64'(got.occupancy));
				end
			end
		end
	end

	// Stimulus: directed corner cases, then random phases.
	initial begin
		logic [63:0] gen_now;
		logic [31:0] gen_id;
		int phase_kind;
		int pick;
		logic [2:0] cmd;
		logic [31:0] sec;
		logic [31:0] nsec;
		logic [31:0] tgt;

		// empty queue, reserved codes
		add_req(ftq_pkg::CMD_QUERY, 64'd0, 32'd0, 32'd0, 32'd0);
		add_req(ftq_pkg::CMD_CHECK, 64'd0, 32'd0, 32'd0, 32'd0);
		add_req(ftq_pkg::CMD_CANCEL, '1, '1, '1, 32'd1);
		add_req(ftq_pkg::CMD_UPTO, '1, '1, '1, '1);
		add_req(CMD_RSVD5, '1, '1, '1, '1);
		add_req(CMD_RSVD6, 64'd0, 32'd0, 32'd0, 32'd0);
		add_req(CMD_RSVD7, '1, '1, '1, '1);
		// deadline saturates; zero delay
		add_req(ftq_pkg::CMD_SET, '1, '1, '1, '1);
		add_req(ftq_pkg::CMD_SET, 64'd0, 32'd0, 32'd0, 32'd0);
		add_req(ftq_pkg::CMD_QUERY, 64'd0, 32'd0, 32'd0, 32'd0);
		add_req(ftq_pkg::CMD_CHECK, 64'd0, 32'd0, 32'd0, 32'd0);     // head not due
		add_req(ftq_pkg::CMD_CANCEL, 64'd0, 32'd0, 32'd0, 32'd1);
		add_req(ftq_pkg::CMD_CHECK, 64'd0, 32'd0, 32'd0, 32'd0);     // fires id 2
		add_req(ftq_pkg::CMD_SET, 64'd1000, 32'd5, 32'd7, 32'd0);
		add_req(ftq_pkg::CMD_SET, 64'd0, 32'd0, '1, 32'd0);
		add_req(ftq_pkg::CMD_QUERY, 64'd2000, 32'd0, 32'd0, 32'd0);  // remaining above 32 bits
		add_req(ftq_pkg::CMD_CANCEL, 64'd0, 32'd0, 32'd0, 32'd99);   // no match
		add_req(ftq_pkg::CMD_UPTO, 64'd0, 32'd0, 32'd0, 32'd0);      // no match
		add_req(ftq_pkg::CMD_UPTO, 64'd0, 32'd0, 32'd0, '1);
		add_req(ftq_pkg::CMD_QUERY, '1, 32'd0, 32'd0, 32'd0);        // clamps to zero
		add_req(ftq_pkg::CMD_CHECK, '1, 32'd0, 32'd0, 32'd0);
		add_req(ftq_pkg::CMD_SET, 64'h8000_0000_0000_0000, 32'd0, 32'd0, 32'd0);
		add_req(ftq_pkg::CMD_CHECK, 64'h8000_0000_0000_0000, 32'd0, 32'd0, 32'd0);

		gen_now = 64'd10_000;
		gen_id = 32'd6;
		phase_kind = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 30 == 0)
				phase_kind = $urandom_range(0, 2);
			gen_now = gen_now + $urandom_range(0, 500);
			if ($urandom_range(0, 49) == 0)
				gen_now = {$urandom, $urandom};
			pick = $urandom_range(0, 99);
			case (phase_kind)
				0: cmd = (pick < 70) ? ftq_pkg::CMD_SET : (pick < 85) ? ftq_pkg::CMD_CHECK :
					(pick < 92) ? ftq_pkg::CMD_QUERY :
					(pick < 96) ? ftq_pkg::CMD_CANCEL : ftq_pkg::CMD_UPTO;
				1: cmd = (pick < 15) ? ftq_pkg::CMD_SET : (pick < 55) ? ftq_pkg::CMD_CHECK :
					(pick < 70) ? ftq_pkg::CMD_QUERY :
					(pick < 85) ? ftq_pkg::CMD_CANCEL : ftq_pkg::CMD_UPTO;
				default: cmd = (pick < 35) ? ftq_pkg::CMD_SET :
					(pick < 60) ? ftq_pkg::CMD_CHECK : (pick < 75) ? ftq_pkg::CMD_QUERY :
					(pick < 87) ? ftq_pkg::CMD_CANCEL : ftq_pkg::CMD_UPTO;
			endcase
			if ($urandom_range(0, 49) == 0)
				cmd = 3'($urandom_range(5, 7));
			pick = $urandom_range(0, 9);
			sec = (pick < 7) ? 32'd0 : (pick < 9) ? $urandom_range(1, 3) : $urandom;
			pick = $urandom_range(0, 9);
			nsec = (pick < 8) ? $urandom_range(0, 5000) : $urandom;
			pick = $urandom_range(0, 9);
			if (pick < 7)
				tgt = gen_id - $urandom_range(1, 20);
			else if (pick < 9)
				tgt = gen_id - $urandom_range(1, 3);
			else
				tgt = $urandom;
			if (cmd == ftq_pkg::CMD_SET)
				gen_id = gen_id + 32'd1;
			add_req(cmd, gen_now, sec, nsec, tgt);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// settle just after each rising edge: all sent, all taken, all checked
		forever begin
			@(posedge clk);
			#1;
			if (pend_q.size() == 0 && !s_tvalid && rsp_q.size() == 0)
				break;
		end
		repeat (40) @(posedge clk);
		if (err_count == 0 && rsp_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

### filelist.f
rtl/ftq_pkg.sv
rtl/ftq_cell.sv
rtl/fifo_timer_queue.sv
sim/fifo_timer_queue_tb.sv
